>>> hw/rtl/rptd_pkg.sv
// Shared types and constants for the block prime finder.
package rptd_pkg;

  localparam int unsigned INDEX_W    = 27;  // block index field
  localparam int unsigned BSIZE_W    = 7;   // block size register
  localparam int unsigned VALUE_W    = 32;  // reported prime field
  localparam int unsigned PROD_W     = INDEX_W + BSIZE_W;
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned CNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int unsigned FIRST_CANDIDATE = 2;
  localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(64);

  // status from the remainder unit back to the sequencer
  typedef struct packed {
    logic done;      // one-cycle pulse when the remainder is ready
    logic rem_zero;  // remainder is zero, valid with done
  } rptd_div_st_t;

endpackage

>>> hw/rtl/rptd_rem_unit.sv
// Restoring remainder unit: one dividend bit per cycle.
module rptd_rem_unit #(
  parameter int unsigned W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [W-1:0]         dividend,
  input  logic [W-1:0]         divisor,
  output rptd_pkg::rptd_div_st_t div_st
);
  import rptd_pkg::*;

  localparam int unsigned CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  always_comb begin
    trial    = {rem_r, dvd_r[W-1]};
    diff     = trial - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the kept bits fit in W
      rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[W-1:0] : trial[W-1:0];
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign div_st.done     = done_r;
  assign div_st.rem_zero = (rem_r == '0);

endmodule

>>> hw/rtl/range_prime_trial_division.sv
// Top level: block prime finder by trial division with a shared remainder unit.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+----------------------------------------
//  in_      | input     | in_valid/in_stall | in_block_index
//  out_     | output    | out_valid/out_stall | out_prime_value, out_found, out_last
//  cfg_     | input     | cfg_we            | cfg_block_size
//
// One item at a time; in_stall is high from acceptance until its last result is loaded.
// Each number n is tested against trial divisors d = 2, 3, ... while d*d <= n, one at a time
// through the bit-serial remainder unit; a divisor that leaves no remainder ends the test.
// Reset is synchronous, active low; block_size resets to 64.
// out_stall holds the result register; the sequencer waits when it must load a new one.
module range_prime_trial_division #(
  parameter int unsigned NUMBER_BITS    = 32,
  parameter int unsigned MAX_BLOCK_SIZE = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rptd_pkg::INDEX_W-1:0]    in_block_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rptd_pkg::VALUE_W-1:0]    out_prime_value,
  output logic                            out_found,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [rptd_pkg::BSIZE_W-1:0]    cfg_block_size
);
  import rptd_pkg::*;

  localparam int unsigned N  = NUMBER_BITS;
  // range arithmetic width: holds b*k and the cap 2^N
  localparam int unsigned EW = (N + 1 > PROD_W) ? N + 1 : PROD_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_NEXT   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_FOUND  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [BSIZE_W-1:0] bsize_r, bsize_nxt;
  logic [BSIZE_W-1:0] b_r, b_nxt;
  logic [INDEX_W-1:0] k_r, k_nxt;
  logic [EW-1:0]      n_r, n_nxt;
  logic [EW-1:0]      end_r, end_nxt;
  logic [N-1:0]       d_r, d_nxt;
  logic [N:0]         sq_r, sq_nxt;
  logic [EW-1:0]      pend_r, pend_nxt;
  logic               have_pend_r, have_pend_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_found_r, out_found_nxt;
  logic               out_last_r, out_last_nxt;

  logic [BSIZE_W-1:0] b_clamp;
  logic [PROD_W-1:0]  prod;
  logic [EW-1:0]      range_end;
  logic [EW-1:0]      range_start;
  logic [EW-1:0]      limit;
  logic               out_free;
  logic               div_start;
  rptd_div_st_t       div_st;

  rptd_rem_unit #(.W(N)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r[N-1:0]),
    .divisor  (d_r),
    .div_st   (div_st)
  );

  assign b_clamp  = (bsize_r > BSIZE_W'(MAX_BLOCK_SIZE)) ? BSIZE_W'(MAX_BLOCK_SIZE) : bsize_r;
  assign prod     = PROD_W'(b_r) * PROD_W'(k_r);
  assign limit    = EW'(1) << N;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    range_end   = EW'(prod);
    range_start = range_end - EW'(b_r);
    if (range_start < EW'(FIRST_CANDIDATE)) range_start = EW'(FIRST_CANDIDATE);
    if (range_end > limit) range_end = limit;
  end

  always_comb begin
    state_nxt     = state_r;
    bsize_nxt     = cfg_we ? cfg_block_size : bsize_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    end_nxt       = end_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          k_nxt         = in_block_index;
          b_nxt         = b_clamp;
          have_pend_nxt = 1'b0;
          count_nxt     = '0;
          state_nxt     = S_SETUP;
        end
      end
      S_SETUP: begin
        n_nxt   = range_start;
        end_nxt = range_end;
        // index zero examines nothing
        state_nxt = (k_r == '0) ? S_FINISH : S_NEXT;
      end
      S_NEXT: begin
        if (n_r < end_r) begin
          d_nxt     = N'(FIRST_CANDIDATE);
          sq_nxt    = (N + 1)'(FIRST_CANDIDATE * FIRST_CANDIDATE);
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_CHECK: begin
        if (sq_r > {1'b0, n_r[N-1:0]}) begin
          state_nxt = S_FOUND;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          if (div_st.rem_zero) begin
            n_nxt     = n_r + EW'(1);
            state_nxt = S_NEXT;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            d_nxt     = d_r + N'(1);
            sq_nxt    = sq_r + {d_r, 1'b1};
            state_nxt = S_CHECK;
          end
        end
      end
      S_FOUND: begin
        // the held prime goes out once a later one shows it is not last
        if (!have_pend_r || out_free) begin
          if (have_pend_r) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = pend_r[VALUE_W-1:0];
            out_found_nxt = 1'b1;
            out_last_nxt  = 1'b0;
          end
          pend_nxt      = n_r;
          have_pend_nxt = 1'b1;
          count_nxt     = count_r + CNT_W'(1);
          if (count_r == CNT_W'(MAX_RESULTS - 1)) begin
            state_nxt = S_FINISH;
          end else begin
            n_nxt     = n_r + EW'(1);
            state_nxt = S_NEXT;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = have_pend_r ? pend_r[VALUE_W-1:0] : '0;
          out_found_nxt = have_pend_r;
          out_last_nxt  = 1'b1;
          have_pend_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bsize_r     <= BSIZE_RESET;
      have_pend_r <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bsize_r     <= bsize_nxt;
      have_pend_r <= have_pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    b_r         <= b_nxt;
    k_r         <= k_nxt;
    n_r         <= n_nxt;
    end_r       <= end_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    pend_r      <= pend_nxt;
    out_value_r <= out_value_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_prime_value = out_value_r;
  assign out_found       = out_found_r;
  assign out_last        = out_last_r;

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !have_pend_r)
    else $error("held prime left over in idle");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RESULTS))
    else $error("result count above cap");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_DIV))
    else $error("remainder done outside divide state");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> out_last_r)
    else $error("empty marker without last");

endmodule
